[hw/rtl/double_ended_priority_queue_top_assert.svh]
// Assertion macros used by the queue controller.
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Checked only while reset is released.
`define DEPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define DEPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/depq_pkg.sv]
// ----------------------------------------------------------------------------
// depq_pkg
// Shared constants, operation codes and control types of the queue.
// ----------------------------------------------------------------------------
package depq_pkg;

    localparam int DEPQ_CAPACITY = 64;
    localparam int DATA_W        = 32;
    localparam int FUNC_W        = 2;
    localparam int HELD_W        = 7;

    localparam logic [FUNC_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [FUNC_W-1:0] OP_DEL_MAX = 2'd1;
    localparam logic [FUNC_W-1:0] OP_DEL_MIN = 2'd2;
    localparam logic [FUNC_W-1:0] OP_CLEAR   = 2'd3;

    localparam logic [1:0] RD_BELOW = 2'd0;
    localparam logic [1:0] RD_MIN   = 2'd1;
    localparam logic [1:0] RD_MAX   = 2'd2;

    typedef struct packed {
        logic       start;
        logic       place;
        logic [1:0] rd_sel;
        logic       lat_min;
        logic       lat_max;
    } t_cmd;

    typedef struct packed {
        logic ins_go;
        logic place_done;
    } t_status;

endpackage

[hw/rtl/double_ended_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// double_ended_priority_queue_top
// Double-ended priority queue of signed values kept sorted in a memory.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  request   in         i_valid / o_ready    i_func, i_value
//  result    out        o_valid / i_ready    o_max_value, o_min_value,
//                                            o_is_empty, o_dropped, o_held
//
// A delete, clear or refused insert goes from transfer through the min read,
// max read and latch to the result. An insert first shifts each larger held
// value up, one at a time via the single memory read port, then the end reads.
// One operation is in flight; the next is taken once the result transfers.
// Reset empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module double_ended_priority_queue_top #(
    parameter int CAPACITY = depq_pkg::DEPQ_CAPACITY
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [depq_pkg::FUNC_W-1:0]        i_func,
    input  logic signed [depq_pkg::DATA_W-1:0] i_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [depq_pkg::DATA_W-1:0] o_max_value,
    output logic signed [depq_pkg::DATA_W-1:0] o_min_value,
    output logic                               o_is_empty,
    output logic                               o_dropped,
    output logic [depq_pkg::HELD_W-1:0]        o_held
);

    depq_pkg::t_cmd    cmd;
    depq_pkg::t_status status;

    depq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    depq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_func      (i_func),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_max_value (o_max_value),
        .o_min_value (o_min_value),
        .o_is_empty  (o_is_empty),
        .o_dropped   (o_dropped),
        .o_held      (o_held)
    );

endmodule

[hw/rtl/depq_ctrl.sv]
// ----------------------------------------------------------------------------
// depq_ctrl
// Sequencer for one operation: update, insertion shift, end reads, result.
// ----------------------------------------------------------------------------
`include "double_ended_priority_queue_top_assert.svh"

module depq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    input  depq_pkg::t_status i_status,
    output depq_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_PLACE = 3'd2;
    localparam logic [2:0] S_RMIN  = 3'd3;
    localparam logic [2:0] S_RMAX  = 3'd4;
    localparam logic [2:0] S_RLAT  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel = depq_pkg::RD_BELOW;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state = i_status.ins_go ? S_READ : S_RMIN;
                end
            end
            S_READ: begin
                n_state = S_PLACE;
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state = i_status.place_done ? S_RMIN : S_READ;
            end
            S_RMIN: begin
                o_cmd.rd_sel = depq_pkg::RD_MIN;
                n_state = S_RMAX;
            end
            S_RMAX: begin
                o_cmd.rd_sel  = depq_pkg::RD_MAX;
                o_cmd.lat_min = 1'b1;
                n_state = S_RLAT;
            end
            S_RLAT: begin
                o_cmd.lat_max = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    `DEPQ_ASSERT(a_no_overlap, i_clk, i_rst_n, !(o_ready && o_valid), "ready while result pending")
    `DEPQ_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_valid && o_ready) |=> !o_ready,
        "accepted a second item at once")
    `DEPQ_ASSERT(a_place_exit, i_clk, i_rst_n,
        (r_state == S_PLACE && i_status.place_done) |=> (r_state == S_RMIN),
        "insertion did not finish after placing the value")

endmodule

[hw/rtl/depq_dpath.sv]
// ----------------------------------------------------------------------------
// depq_dpath
// Sorted circular store with head pointer, count, and result registers.
// ----------------------------------------------------------------------------
module depq_dpath #(
    parameter int CAPACITY = depq_pkg::DEPQ_CAPACITY
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [depq_pkg::FUNC_W-1:0]        i_func,
    input  logic signed [depq_pkg::DATA_W-1:0] i_value,
    input  depq_pkg::t_cmd                     i_cmd,
    output depq_pkg::t_status                  o_status,
    output logic signed [depq_pkg::DATA_W-1:0] o_max_value,
    output logic signed [depq_pkg::DATA_W-1:0] o_min_value,
    output logic                               o_is_empty,
    output logic                               o_dropped,
    output logic [depq_pkg::HELD_W-1:0]        o_held
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [depq_pkg::DATA_W-1:0] r_mem [CAPACITY];

    logic [AW-1:0]                      r_head;
    logic [CW-1:0]                      r_count;
    logic [CW-1:0]                      r_pos;
    logic signed [depq_pkg::DATA_W-1:0] r_value;
    logic signed [depq_pkg::DATA_W-1:0] r_rdata;
    logic signed [depq_pkg::DATA_W-1:0] r_max;
    logic signed [depq_pkg::DATA_W-1:0] r_min;
    logic                               r_dropped;

    logic [AW-1:0]                      rd_addr;
    logic [AW-1:0]                      wr_addr;
    logic signed [depq_pkg::DATA_W-1:0] wr_data;
    logic                               full;
    logic                               empty;

    // Offsets whose results are used stay below CAPACITY, so one conditional subtract wraps the sum.
    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] base,
                                             input logic [CW-1:0] offs);
        logic [AW+1:0] sum;
        sum = (AW+2)'(base) + (AW+2)'(offs);
        if (sum >= (AW+2)'(CAPACITY)) begin
            sum = sum - (AW+2)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    assign full  = (r_count == CW'(CAPACITY));
    assign empty = (r_count == '0);

    assign o_status.ins_go     = (i_func == depq_pkg::OP_INSERT) && !full;
    assign o_status.place_done = (r_pos == '0) || !(r_rdata > r_value);

    always_comb begin
        case (i_cmd.rd_sel)
            depq_pkg::RD_MIN: rd_addr = r_head;
            depq_pkg::RD_MAX: rd_addr = f_wrap(r_head, r_count - CW'(1));
            default:          rd_addr = f_wrap(r_head, (r_pos == '0) ? '0 : r_pos - CW'(1));
        endcase
    end

    assign wr_addr = f_wrap(r_head, r_pos);
    assign wr_data = o_status.place_done ? r_value : r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.place) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else if (i_cmd.start) begin
            r_dropped <= (i_func == depq_pkg::OP_INSERT) && full;
            case (i_func)
                depq_pkg::OP_DEL_MAX: begin
                    if (!empty) r_count <= r_count - CW'(1);
                end
                depq_pkg::OP_DEL_MIN: begin
                    if (!empty) begin
                        r_count <= r_count - CW'(1);
                        r_head  <= f_wrap(r_head, CW'(1));
                    end
                end
                depq_pkg::OP_CLEAR: begin
                    r_count <= '0;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.place && o_status.place_done) begin
            r_count <= r_count + CW'(1);
        end
    end

    // The insertion walk starts at the top and moves larger values up one cell.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_value <= i_value;
            r_pos   <= r_count;
        end else if (i_cmd.place && !o_status.place_done) begin
            r_pos <= r_pos - CW'(1);
        end
        if (i_cmd.lat_min) begin
            r_min <= empty ? '0 : r_rdata;
        end
        if (i_cmd.lat_max) begin
            r_max <= empty ? '0 : r_rdata;
        end
    end

    assign o_max_value = r_max;
    assign o_min_value = r_min;
    assign o_is_empty  = empty;
    assign o_dropped   = r_dropped;
    assign o_held      = depq_pkg::HELD_W'(r_count);

endmodule

[dv/depq_checker.sv]
// ----------------------------------------------------------------------------
// depq_checker
// Watches both channels of the queue, keeps a sorted shadow of its contents,
// and compares every result transfer against the predicted summary.
// ----------------------------------------------------------------------------
module depq_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic                               i_ready_in,
    input  logic [depq_pkg::FUNC_W-1:0]        i_func,
    input  logic signed [depq_pkg::DATA_W-1:0] i_value,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic signed [depq_pkg::DATA_W-1:0] i_max_value,
    input  logic signed [depq_pkg::DATA_W-1:0] i_min_value,
    input  logic                               i_is_empty,
    input  logic                               i_dropped,
    input  logic [depq_pkg::HELD_W-1:0]        i_held,
    output int                                 o_errors,
    output int                                 o_pending
);

    typedef struct packed {
        logic signed [depq_pkg::DATA_W-1:0] max_v;
        logic signed [depq_pkg::DATA_W-1:0] min_v;
        logic                               empty;
        logic                               drop;
        logic [depq_pkg::HELD_W-1:0]        held;
    } t_summary;

    logic signed [depq_pkg::DATA_W-1:0] shadow[$];
    t_summary                           summaries[$];

    assign o_pending = summaries.size();

    function automatic t_summary apply_op(logic [depq_pkg::FUNC_W-1:0] op,
                                          logic signed [depq_pkg::DATA_W-1:0] v);
        t_summary s;
        int       pos;
        s.drop = 1'b0;
        case (op)
            depq_pkg::OP_INSERT: begin
                if (shadow.size() >= depq_pkg::DEPQ_CAPACITY) begin
                    s.drop = 1'b1;
                end else begin
                    // Equal values go after the copies already held.
                    pos = shadow.size();
                    while (pos > 0 && shadow[pos-1] > v) pos--;
                    shadow.insert(pos, v);
                end
            end
            depq_pkg::OP_DEL_MAX: if (shadow.size() > 0) void'(shadow.pop_back());
            depq_pkg::OP_DEL_MIN: if (shadow.size() > 0) void'(shadow.pop_front());
            default: shadow.delete();
        endcase
        s.empty = (shadow.size() == 0);
        s.max_v = s.empty ? '0 : shadow[$];
        s.min_v = s.empty ? '0 : shadow[0];
        s.held  = depq_pkg::HELD_W'(shadow.size());
        return s;
    endfunction

    always @(posedge i_clk) begin
        t_summary got;
        t_summary want;
        if (i_rst_n) begin
            if (i_valid && i_ready_in) summaries.push_back(apply_op(i_func, i_value));
            if (i_out_valid && i_out_ready) begin
                got = '{i_max_value, i_min_value, i_is_empty, i_dropped, i_held};
                if (summaries.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10) $display("unexpected result transfer %p", got);
                end else begin
                    want = summaries.pop_front();
                    if (got !== want) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
        end
    end

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives random and directed queue operations under varying backpressure and
// reports the verdict from the checker's error and pending counts.
// ----------------------------------------------------------------------------
module tb;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_valid = 1'b0;
    logic                               o_ready;
    logic [depq_pkg::FUNC_W-1:0]        i_func = depq_pkg::OP_CLEAR;
    logic signed [depq_pkg::DATA_W-1:0] i_value = '0;
    logic                               o_valid;
    logic                               i_ready = 1'b0;
    logic signed [depq_pkg::DATA_W-1:0] o_max_value;
    logic signed [depq_pkg::DATA_W-1:0] o_min_value;
    logic                               o_is_empty;
    logic                               o_dropped;
    logic [depq_pkg::HELD_W-1:0]        o_held;
    int                                 errors;
    int                                 pending;
    int                                 send_idle = 0;
    int                                 recv_stall = 0;
    int                                 hold_off = 0;
    logic                               hold_req = 1'b0;
    logic                               hold_ack = 1'b0;
    int                                 quiet = 0;

    always #2 i_clk = ~i_clk;

    double_ended_priority_queue_top u_top (.*);

    depq_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_func(i_func), .i_value(i_value), .i_out_valid(o_valid),
        .i_out_ready(i_ready), .i_max_value(o_max_value), .i_min_value(o_min_value),
        .i_is_empty(o_is_empty), .i_dropped(o_dropped), .i_held(o_held),
        .o_errors(errors), .o_pending(pending)
    );

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_off <= 300;
            i_ready  <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready  <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 20000) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic signed [depq_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(7)) - 32'd3);
            default: return $signed($urandom());
        endcase
    endfunction

    // Valid stays high after a transfer until the next send or drain decides.
    task automatic send(logic [depq_pkg::FUNC_W-1:0] op,
                        logic signed [depq_pkg::DATA_W-1:0] v);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_func  <= op;
        i_value <= v;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        logic [depq_pkg::FUNC_W-1:0] op;
        int                          n;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // Directed: deletes on empty, extremes, duplicates, clear.
        send(depq_pkg::OP_DEL_MAX, 0);
        send(depq_pkg::OP_DEL_MIN, 0);
        send(depq_pkg::OP_INSERT, 32'sh7fffffff);
        send(depq_pkg::OP_INSERT, 32'sh80000000);
        send(depq_pkg::OP_INSERT, 5);
        send(depq_pkg::OP_INSERT, 5);
        send(depq_pkg::OP_INSERT, -1);
        send(depq_pkg::OP_DEL_MAX, 0);
        send(depq_pkg::OP_DEL_MIN, 0);
        send(depq_pkg::OP_DEL_MIN, 0);
        send(depq_pkg::OP_CLEAR, 0);
        send(depq_pkg::OP_DEL_MAX, 0);
        // Fill past capacity to see refused inserts, with the fill stalled.
        hold_req = ~hold_req;
        for (n = 0; n < depq_pkg::DEPQ_CAPACITY + 2; n++)
            send(depq_pkg::OP_INSERT, pick_value());
        send(depq_pkg::OP_INSERT, -32'sd5);
        drain();
        send(depq_pkg::OP_CLEAR, 0);
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 86; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 86; end
                default: begin send_idle = 6; recv_stall = 6; end
            endcase
            for (n = 0; n < 160; n++) begin
                // Insert-heavy; in the first 60 operations clears become inserts so the queue grows deep.
                case ($urandom_range(19))
                    0: op = depq_pkg::OP_CLEAR;
                    1, 2, 3, 4: op = depq_pkg::OP_DEL_MAX;
                    5, 6, 7, 8: op = depq_pkg::OP_DEL_MIN;
                    default: op = depq_pkg::OP_INSERT;
                endcase
                if (n < 60 && op == depq_pkg::OP_CLEAR) op = depq_pkg::OP_INSERT;
                send(op, pick_value());
            end
            drain();
        end
        drain();
        repeat (20) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
